// ===== src/alnpid_pkg.sv =====
package alnpid_pkg;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 17;
    localparam int START_W    = 16;
    localparam int PCT_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Default column cap handed to the top level
    localparam int DEFAULT_MAX_COLUMNS = 65536;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_MODE   = 2'd0,
        CFG_START_COLUMN = 2'd1,
        CFG_MIN_ALIGNED  = 2'd2
    } t_cfg_index;

    // Controller states
    typedef enum logic [1:0] {
        ST_COUNT,
        ST_SETUP,
        ST_DIV,
        ST_LOAD
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic setup;
        logic div_step;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_busy;
    } t_status;

endpackage

// ===== src/alnpid_col_if.sv =====
interface alnpid_col_if;
    import alnpid_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] s_char;
    logic [CHAR_W-1:0] t_char;
    logic              last_column;

    modport source (output valid, output s_char, output t_char, output last_column,
                    input ready);
    modport sink   (input valid, input s_char, input t_char, input last_column,
                    output ready);
endinterface

// ===== src/alnpid_res_if.sv =====
interface alnpid_res_if;
    import alnpid_pkg::*;

    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] percent_q8;
    logic [CNT_W-1:0] aligned_total;
    logic [CNT_W-1:0] match_total;
    logic             none_aligned;

    modport source (output valid, output percent_q8, output aligned_total,
                    output match_total, output none_aligned, input ready);
    modport sink   (input valid, input percent_q8, input aligned_total,
                    input match_total, input none_aligned, output ready);
endinterface

// ===== src/alignment_percent_identity_core.sv =====
// Percent identity of a pairwise alignment. Each transfer on i_col brings one
// alignment column (one character of each sequence); columns stream in at one
// per cycle while i_col is ready. The column flagged last_column is counted and
// then produces one transfer on o_res with the aligned and matching counts and
// the percent: rounded integer percent in gap mode, truncated Q7.8 in
// nucleotide mode. After the last column, i_col stays not ready through a setup
// state, the 15 steps of the bit-serial restoring divider and a load state, and
// longer while the previous result still sits unread in the output register.
// The counters saturate at the smaller of MAX_COLUMNS and 131071. Configuration
// writes take effect at once and should only be made between alignments.
module alignment_percent_identity_core #(
    parameter int MAX_COLUMNS = alnpid_pkg::DEFAULT_MAX_COLUMNS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [alnpid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [alnpid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    alnpid_col_if.sink                       i_col,
    alnpid_res_if.source                     o_res
);
    import alnpid_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    alnpid_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_col_valid   (i_col.valid),
        .i_last_column (i_col.last_column),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Counters, divider and output register
    alnpid_dp #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_col_valid     (i_col.valid),
        .i_s_char        (i_col.s_char),
        .i_t_char        (i_col.t_char),
        .i_last_column   (i_col.last_column),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_res_ready     (o_res.ready),
        .o_res_valid     (o_res.valid),
        .o_percent_q8    (o_res.percent_q8),
        .o_aligned_total (o_res.aligned_total),
        .o_match_total   (o_res.match_total),
        .o_none_aligned  (o_res.none_aligned)
    );

    assign i_col.ready = cmd.in_ready;

endmodule

// ===== src/alnpid_ctrl.sv =====
module alnpid_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_col_valid,
    input  logic                i_last_column,
    input  alnpid_pkg::t_status i_status,
    output alnpid_pkg::t_cmd    o_cmd
);
    import alnpid_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COUNT: begin
                if (i_col_valid && i_last_column) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!i_status.out_busy) begin
                    n_state = ST_COUNT;
                end
            end
            default: begin
                n_state = ST_COUNT;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_COUNT: o_cmd.in_ready = 1'b1;
            ST_SETUP: o_cmd.setup    = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_LOAD:  o_cmd.load_out = !i_status.out_busy;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ===== src/alnpid_dp.sv =====
module alnpid_dp #(
    parameter int MAX_COLUMNS = alnpid_pkg::DEFAULT_MAX_COLUMNS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [alnpid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [alnpid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_col_valid,
    input  logic [alnpid_pkg::CHAR_W-1:0]     i_s_char,
    input  logic [alnpid_pkg::CHAR_W-1:0]     i_t_char,
    input  logic                             i_last_column,
    input  alnpid_pkg::t_cmd                 i_cmd,
    output alnpid_pkg::t_status              o_status,
    input  logic                             i_res_ready,
    output logic                             o_res_valid,
    output logic [alnpid_pkg::PCT_W-1:0]      o_percent_q8,
    output logic [alnpid_pkg::CNT_W-1:0]      o_aligned_total,
    output logic [alnpid_pkg::CNT_W-1:0]      o_match_total,
    output logic                             o_none_aligned
);
    import alnpid_pkg::*;

    localparam int               CAP_INT   = (MAX_COLUMNS < 131071) ? MAX_COLUMNS : 131071;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);
    localparam int               NUM_W     = 33;
    localparam int               DSH_W     = 32;
    localparam int               DEN_W     = CNT_W + 1;
    localparam int               STEP_W    = $clog2(PCT_W);
    localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
    localparam logic [NUM_W-1:0] NUC_SCALE = 33'd25600;
    localparam logic [NUM_W-1:0] GAP_SCALE = 33'd200;

    function automatic logic [CHAR_W-1:0] upper_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            u = c - 8'h20;
        end
        return u;
    endfunction

    function automatic logic is_nuc(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        u = upper_of(c);
        return (u == 8'h41) || (u == 8'h43) || (u == 8'h47) || (u == 8'h54);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < COUNT_CAP) ? v + 1'b1 : COUNT_CAP;
    endfunction

    // Configuration registers
    logic               r_count_mode;
    logic [START_W-1:0] r_start_column;
    logic [CNT_W-1:0]   r_min_aligned;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode   <= 1'b0;
            r_start_column <= '0;
            r_min_aligned  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_COUNT_MODE:   r_count_mode   <= i_cfg_data[0];
                CFG_START_COLUMN: r_start_column <= i_cfg_data[START_W-1:0];
                CFG_MIN_ALIGNED:  r_min_aligned  <= i_cfg_data[CNT_W-1:0];
                default:          r_count_mode   <= r_count_mode;
            endcase
        end
    end

    // Column evaluation
    logic             col_fire;
    logic             col_live;
    logic             col_aligned;
    logic             col_match;
    logic [CNT_W-1:0] n_aligned;
    logic [CNT_W-1:0] n_match;
    logic [CNT_W-1:0] n_col_idx;

    logic [CNT_W-1:0] r_aligned;
    logic [CNT_W-1:0] r_match;
    logic [CNT_W-1:0] r_col_idx;
    logic [CNT_W-1:0] r_aligned_res;
    logic [CNT_W-1:0] r_match_res;

    assign col_fire = i_col_valid && i_cmd.in_ready;
    assign col_live = r_col_idx >= {1'b0, r_start_column};
    assign col_match = upper_of(i_s_char) == upper_of(i_t_char);

    always_comb begin
        if (r_count_mode) begin
            col_aligned = is_nuc(i_s_char) && is_nuc(i_t_char);
        end else begin
            col_aligned = (i_s_char != CHAR_DASH) && (i_t_char != CHAR_DASH);
        end
        n_aligned = r_aligned;
        n_match   = r_match;
        if (col_live && col_aligned) begin
            n_aligned = sat_inc(r_aligned);
            if (col_match) begin
                n_match = sat_inc(r_match);
            end
        end
        n_col_idx = sat_inc(r_col_idx);
    end

    // Running counters; snapshot and clear on the last column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aligned <= '0;
            r_match   <= '0;
            r_col_idx <= '0;
        end else if (col_fire) begin
            if (i_last_column) begin
                r_aligned <= '0;
                r_match   <= '0;
                r_col_idx <= '0;
            end else begin
                r_aligned <= n_aligned;
                r_match   <= n_match;
                r_col_idx <= n_col_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (col_fire && i_last_column) begin
            r_aligned_res <= n_aligned;
            r_match_res   <= n_match;
        end
    end

    // Divider setup: numerator and denominator of the final percent
    logic             skip;
    logic [NUM_W-1:0] scale;
    logic [NUM_W-1:0] prod;
    logic [DEN_W-1:0] den;

    assign skip  = (r_aligned_res == '0) ||
                   (r_count_mode && (r_aligned_res < r_min_aligned));
    assign scale = r_count_mode ? NUC_SCALE : GAP_SCALE;
    assign prod  = (NUM_W'(r_match_res) * scale) +
                   (r_count_mode ? '0 : NUM_W'(r_aligned_res));

    always_comb begin
        if (skip) begin
            den = DEN_W'(1);
        end else if (r_count_mode) begin
            den = {1'b0, r_aligned_res};
        end else begin
            den = {r_aligned_res, 1'b0};
        end
    end

    // Restoring divider, one quotient bit per cycle
    logic [NUM_W-1:0]  r_num;
    logic [DSH_W-1:0]  r_dsh;
    logic [PCT_W-1:0]  r_quot;
    logic [STEP_W-1:0] r_step;
    logic              fits;

    assign fits = {1'b0, r_dsh} <= r_num;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_num  <= skip ? '0 : prod;
            r_dsh  <= DSH_W'(den) << (PCT_W - 1);
            r_quot <= '0;
            r_step <= STEP_W'(PCT_W - 1);
        end else if (i_cmd.div_step) begin
            if (fits) begin
                r_num <= r_num - {1'b0, r_dsh};
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[PCT_W-2:0], fits};
            r_step <= r_step - 1'b1;
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_percent_q8    <= r_quot;
            o_aligned_total <= r_aligned_res;
            o_match_total   <= r_match_res;
            o_none_aligned  <= (r_aligned_res == '0);
        end
    end

    assign o_res_valid       = r_out_valid;
    assign o_status.div_last = (r_step == '0);
    assign o_status.out_busy = r_out_valid && !i_res_ready;

endmodule

// ===== src/alnpid_checker.sv =====
module alnpid_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_col_valid,
    input logic                        i_col_ready,
    input logic                        i_col_last,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [alnpid_pkg::PCT_W-1:0] i_percent_q8,
    input logic [alnpid_pkg::CNT_W-1:0] i_aligned_total,
    input logic [alnpid_pkg::CNT_W-1:0] i_match_total,
    input logic                        i_none_aligned
);
    import alnpid_pkg::*;

    // A stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_percent_q8) &&
            $stable(i_aligned_total) && $stable(i_match_total))
        else $error("result payload changed while stalled");

    // Column input closes while the final percent is worked out
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_col_valid && i_col_ready && i_col_last |=> !i_col_ready)
        else $error("column accepted during divide");

    // No aligned column forces a zero percent and a zero count
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_none_aligned |-> (i_percent_q8 == '0) &&
            (i_aligned_total == '0))
        else $error("none_aligned with nonzero result");

    // Matches never exceed aligned columns, percent stays in range
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_match_total <= i_aligned_total) &&
            (i_percent_q8 <= 15'd25600))
        else $error("result counts inconsistent");

endmodule

bind alignment_percent_identity_core alnpid_checker u_alnpid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_col_valid     (i_col.valid),
    .i_col_ready     (i_col.ready),
    .i_col_last      (i_col.last_column),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_percent_q8    (o_res.percent_q8),
    .i_aligned_total (o_res.aligned_total),
    .i_match_total   (o_res.match_total),
    .i_none_aligned  (o_res.none_aligned)
);
